/* design/mdms_pkg.sv */
// ----------------------------------------------------------------------------
// mdms_pkg
// Shared types, SFR addresses and the opcode decoder of the data-move core.
// ----------------------------------------------------------------------------
package mdms_pkg;

	localparam logic [7:0] ADDR_PSW = 8'hD0;
	localparam logic [7:0] ADDR_ACC = 8'hE0;
	localparam logic [7:0] ADDR_DPL = 8'h82;
	localparam logic [7:0] ADDR_DPH = 8'h83;

	localparam logic [7:0] OP_RR_A   = 8'h03;
	localparam logic [7:0] OP_RL_A   = 8'h23;
	localparam logic [7:0] OP_SWAP_A = 8'hC4;
	localparam logic [7:0] OP_CLR_A  = 8'hE4;
	localparam logic [7:0] OP_MOV_DP = 8'h90;
	localparam logic [7:0] OP_MOVX   = 8'hF0;

	localparam logic [3:0] ROW_INC    = 4'h0;
	localparam logic [3:0] ROW_DEC    = 4'h1;
	localparam logic [3:0] ROW_MOVIMM = 4'h7;
	localparam logic [3:0] ROW_MOVDIR = 4'h8;
	localparam logic [3:0] ROW_MOVTOR = 4'hA;
	localparam logic [3:0] ROW_MOVTOA = 4'hE;
	localparam logic [3:0] ROW_MOVFRA = 4'hF;

	localparam logic [3:0] COL_ACC = 4'h4;
	localparam logic [3:0] COL_DIR = 4'h5;
	localparam logic [3:0] COL_IND = 4'h6;

	typedef enum logic [2:0] {
		ADR_ACC, ADR_DIR1, ADR_DIR2, ADR_IND, ADR_REG, ADR_DPH
	} adr_t;

	typedef enum logic [2:0] {
		SRC_ACC, SRC_IMM1, SRC_IMM2, SRC_MEM, SRC_ZERO
	} src_t;

	typedef enum logic [2:0] {
		ALU_PASS, ALU_INC, ALU_DEC, ALU_RR, ALU_RL, ALU_SWAP
	} alu_t;

	typedef struct packed {
		src_t       src;
		adr_t       src_adr;
		adr_t       dst_adr;
		alu_t       alu;
		logic       wr;
		logic       dptr;
		logic       movx;
		logic       bad;
		logic [1:0] len;
	} dec_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SRC, ST_EXEC, ST_DPL, ST_FINISH
	} state_t;

	typedef enum logic {RD_PTR, RD_SRC} rd_sel_t;

	typedef enum logic [1:0] {WR_NONE, WR_CLEAR, WR_EXEC, WR_DPL} wr_sel_t;

	typedef struct packed {
		logic       ins_load;
		logic       ptr_load;
		rd_sel_t    rd_sel;
		wr_sel_t    wr_sel;
		logic [7:0] clr_addr;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic two_writes;
	} dp_stat_t;

	function automatic dec_t decode(input logic [7:0] op);
		dec_t       d;
		logic [3:0] hi;
		logic [3:0] lo;
		adr_t       rn;
		d.src     = SRC_ACC;
		d.src_adr = ADR_ACC;
		d.dst_adr = ADR_ACC;
		d.alu     = ALU_PASS;
		d.wr      = 1'b0;
		d.dptr    = 1'b0;
		d.movx    = 1'b0;
		d.bad     = 1'b0;
		d.len     = 2'd1;
		hi = op[7:4];
		lo = op[3:0];
		// columns 6..7 are @Ri, 8..F are Rn
		rn = lo[3] ? ADR_REG : ADR_IND;
		if ((hi == ROW_INC || hi == ROW_DEC) && lo >= COL_ACC) begin
			d.wr  = 1'b1;
			d.alu = (hi == ROW_INC) ? ALU_INC : ALU_DEC;
			d.src = SRC_MEM;
			if (lo == COL_ACC) begin
				d.dst_adr = ADR_ACC;
			end else if (lo == COL_DIR) begin
				d.dst_adr = ADR_DIR1;
				d.len     = 2'd2;
			end else begin
				d.dst_adr = rn;
			end
			d.src_adr = d.dst_adr;
		end else if (op == OP_RR_A) begin
			d.wr  = 1'b1;
			d.alu = ALU_RR;
		end else if (op == OP_RL_A) begin
			d.wr  = 1'b1;
			d.alu = ALU_RL;
		end else if (op == OP_SWAP_A) begin
			d.wr  = 1'b1;
			d.alu = ALU_SWAP;
		end else if (op == OP_CLR_A) begin
			d.wr  = 1'b1;
			d.src = SRC_ZERO;
		end else if (hi == ROW_MOVIMM && lo >= COL_ACC) begin
			d.wr  = 1'b1;
			d.src = SRC_IMM1;
			d.len = 2'd2;
			if (lo == COL_ACC) begin
				d.dst_adr = ADR_ACC;
			end else if (lo == COL_DIR) begin
				d.src     = SRC_IMM2;
				d.dst_adr = ADR_DIR1;
				d.len     = 2'd3;
			end else begin
				d.dst_adr = rn;
			end
		end else if (hi == ROW_MOVDIR && lo >= COL_DIR) begin
			d.wr  = 1'b1;
			d.src = SRC_MEM;
			if (lo == COL_DIR) begin
				d.src_adr = ADR_DIR1;
				d.dst_adr = ADR_DIR2;
				d.len     = 2'd3;
			end else begin
				d.src_adr = rn;
				d.dst_adr = ADR_DIR1;
				d.len     = 2'd2;
			end
		end else if (op == OP_MOV_DP) begin
			d.wr      = 1'b1;
			d.dptr    = 1'b1;
			d.src     = SRC_IMM1;
			d.dst_adr = ADR_DPH;
			d.len     = 2'd3;
		end else if (hi == ROW_MOVTOR && lo >= COL_IND) begin
			d.wr      = 1'b1;
			d.src     = SRC_MEM;
			d.src_adr = ADR_DIR1;
			d.dst_adr = rn;
			d.len     = 2'd2;
		end else if (hi == ROW_MOVTOA && lo >= COL_DIR) begin
			d.wr      = 1'b1;
			d.src     = SRC_MEM;
			d.dst_adr = ADR_ACC;
			if (lo == COL_DIR) begin
				d.src_adr = ADR_DIR1;
				d.len     = 2'd2;
			end else begin
				d.src_adr = rn;
			end
		end else if (op == OP_MOVX) begin
			d.movx = 1'b1;
		end else if (hi == ROW_MOVFRA && lo >= COL_DIR) begin
			d.wr  = 1'b1;
			d.src = SRC_ACC;
			if (lo == COL_DIR) begin
				d.dst_adr = ADR_DIR1;
				d.len     = 2'd2;
			end else begin
				d.dst_adr = rn;
			end
		end else begin
			d.bad = 1'b1;
		end
		return d;
	endfunction

endpackage

/* design/mcs51_data_move_subset_core_unit.sv */
// ----------------------------------------------------------------------------
// mcs51_data_move_subset_core_unit
// Executes one instruction of an 8051 data-move subset per request.
// ----------------------------------------------------------------------------
// Each request carries an opcode and two operand bytes and yields one result:
// the new PC, the accumulator, an external-memory write (MOVX @DPTR,A) and an
// unsupported flag. After reset the block sweeps its 256-byte internal RAM to
// zero, one byte a cycle, and takes no request until the sweep ends. Each
// instruction then runs in steps, set by the single-port internal RAM, and
// no new request is taken until its result is loaded: the @Ri pointer is
// read as the request is taken, the source byte next, then one write-back
// (two for MOV DPTR,#data), then the result is loaded. A result still
// waiting on the output holds only the final load step.
// ----------------------------------------------------------------------------
module mcs51_data_move_subset_core_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand_one,
	input  logic [7:0]  operand_two,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] program_counter,
	output logic [7:0]  accumulator,
	output logic        xram_write,
	output logic [15:0] xram_address,
	output logic [7:0]  xram_data,
	output logic        unsupported
);

	mdms_pkg::ctrl_cmd_t cmd;
	mdms_pkg::dp_stat_t  stat;

	// sequence the steps of each request and own both handshakes
	mdms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// hold RAM, SFR mirrors, PC and the result register
	mdms_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.operand_one     (operand_one),
		.operand_two     (operand_two),
		.program_counter (program_counter),
		.accumulator     (accumulator),
		.xram_write      (xram_write),
		.xram_address    (xram_address),
		.xram_data       (xram_data),
		.unsupported     (unsupported)
	);

endmodule

/* design/mdms_ctrl.sv */
// ----------------------------------------------------------------------------
// mdms_ctrl
// Sequencer: RAM clearing sweep, instruction steps and the result handshake.
// ----------------------------------------------------------------------------
module mdms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mdms_pkg::dp_stat_t   stat,
	output mdms_pkg::ctrl_cmd_t  cmd
);

	mdms_pkg::state_t state_q, state_d;
	logic [7:0]       clr_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mdms_pkg::ST_CLEAR;
			clr_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mdms_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 8'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.ins_load = 1'b0;
		cmd.ptr_load = 1'b0;
		cmd.rd_sel   = mdms_pkg::RD_PTR;
		cmd.wr_sel   = mdms_pkg::WR_NONE;
		cmd.clr_addr = clr_q;
		cmd.out_load = 1'b0;
		unique case (state_q)
			mdms_pkg::ST_CLEAR: begin
				cmd.wr_sel = mdms_pkg::WR_CLEAR;
				if (clr_q == 8'hFF) begin
					state_d = mdms_pkg::ST_IDLE;
				end
			end
			mdms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ins_load = 1'b1;
					state_d      = mdms_pkg::ST_SRC;
				end
			end
			mdms_pkg::ST_SRC: begin
				cmd.rd_sel   = mdms_pkg::RD_SRC;
				cmd.ptr_load = 1'b1;
				state_d      = mdms_pkg::ST_EXEC;
			end
			mdms_pkg::ST_EXEC: begin
				cmd.wr_sel = mdms_pkg::WR_EXEC;
				state_d    = stat.two_writes ? mdms_pkg::ST_DPL : mdms_pkg::ST_FINISH;
			end
			mdms_pkg::ST_DPL: begin
				cmd.wr_sel = mdms_pkg::WR_DPL;
				state_d    = mdms_pkg::ST_FINISH;
			end
			mdms_pkg::ST_FINISH: begin
				// hold until the result register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = mdms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdms_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* design/mdms_dpath.sv */
// ----------------------------------------------------------------------------
// mdms_dpath
// Internal RAM, SFR mirrors, program counter, byte ALU and result register.
// ----------------------------------------------------------------------------
module mdms_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdms_pkg::ctrl_cmd_t  cmd,
	output mdms_pkg::dp_stat_t   stat,
	input  logic [7:0]           opcode,
	input  logic [7:0]           operand_one,
	input  logic [7:0]           operand_two,
	output logic [15:0]          program_counter,
	output logic [7:0]           accumulator,
	output logic                 xram_write,
	output logic [15:0]          xram_address,
	output logic [7:0]           xram_data,
	output logic                 unsupported
);

	logic [7:0] mem [256];

	logic [7:0]  opcode_q, b1_q, b2_q;
	logic [7:0]  rdata_q, ptr_q;
	logic [7:0]  acc_q, psw_q, dpl_q, dph_q;
	logic [15:0] pc_q;

	mdms_pkg::dec_t dec;
	logic [7:0]     rd_addr, src_addr, dst_addr;
	logic [7:0]     src_val, alu_val;
	logic           wr_en;
	logic [7:0]     wr_addr, wr_data;
	logic [15:0]    pc_next;

	function automatic logic [7:0] resolve(input mdms_pkg::adr_t k, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] ptr, input logic [1:0] bank,
			input logic [2:0] idx);
		logic [7:0] a;
		case (k)
			mdms_pkg::ADR_ACC:  a = mdms_pkg::ADDR_ACC;
			mdms_pkg::ADR_DIR1: a = b1;
			mdms_pkg::ADR_DIR2: a = b2;
			mdms_pkg::ADR_IND:  a = ptr;
			mdms_pkg::ADR_REG:  a = {3'b000, bank, idx};
			mdms_pkg::ADR_DPH:  a = mdms_pkg::ADDR_DPH;
			default:            a = mdms_pkg::ADDR_ACC;
		endcase
		return a;
	endfunction

	assign dec             = mdms_pkg::decode(opcode_q);
	assign stat.two_writes = dec.dptr;

	// pointer fetched while the instruction is taken: rdata_q holds @Ri in SRC
	assign src_addr = resolve(dec.src_adr, b1_q, b2_q, rdata_q, psw_q[4:3], opcode_q[2:0]);
	assign dst_addr = resolve(dec.dst_adr, b1_q, b2_q, ptr_q, psw_q[4:3], opcode_q[2:0]);
	assign rd_addr  = (cmd.rd_sel == mdms_pkg::RD_SRC) ? src_addr
			: {3'b000, psw_q[4:3], 2'b00, opcode[0]};

	always_comb begin
		case (dec.src)
			mdms_pkg::SRC_ACC:  src_val = acc_q;
			mdms_pkg::SRC_IMM1: src_val = b1_q;
			mdms_pkg::SRC_IMM2: src_val = b2_q;
			mdms_pkg::SRC_MEM:  src_val = rdata_q;
			default:            src_val = 8'd0;
		endcase
		case (dec.alu)
			mdms_pkg::ALU_INC:  alu_val = src_val + 8'd1;
			mdms_pkg::ALU_DEC:  alu_val = src_val - 8'd1;
			mdms_pkg::ALU_RR:   alu_val = {src_val[0], src_val[7:1]};
			mdms_pkg::ALU_RL:   alu_val = {src_val[6:0], src_val[7]};
			mdms_pkg::ALU_SWAP: alu_val = {src_val[3:0], src_val[7:4]};
			default:            alu_val = src_val;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = dst_addr;
		wr_data = alu_val;
		case (cmd.wr_sel)
			mdms_pkg::WR_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cmd.clr_addr;
				wr_data = 8'd0;
			end
			mdms_pkg::WR_EXEC: begin
				wr_en = dec.wr;
			end
			mdms_pkg::WR_DPL: begin
				wr_en   = 1'b1;
				wr_addr = mdms_pkg::ADDR_DPL;
				wr_data = b2_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_load) begin
			opcode_q <= opcode;
			b1_q     <= operand_one;
			b2_q     <= operand_two;
		end
		if (cmd.ptr_load) begin
			ptr_q <= rdata_q;
		end
	end

	// mirror the SFRs that the core reads at fixed places
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'd0;
			psw_q <= 8'd0;
			dpl_q <= 8'd0;
			dph_q <= 8'd0;
		end else if (wr_en) begin
			if (wr_addr == mdms_pkg::ADDR_ACC) acc_q <= wr_data;
			if (wr_addr == mdms_pkg::ADDR_PSW) psw_q <= wr_data;
			if (wr_addr == mdms_pkg::ADDR_DPL) dpl_q <= wr_data;
			if (wr_addr == mdms_pkg::ADDR_DPH) dph_q <= wr_data;
		end
	end

	assign pc_next = pc_q + {14'd0, dec.len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 16'd0;
		end else if (cmd.out_load) begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			program_counter <= pc_next;
			accumulator     <= acc_q;
			xram_write      <= dec.movx;
			xram_address    <= dec.movx ? {dph_q, dpl_q} : 16'd0;
			xram_data       <= dec.movx ? acc_q : 8'd0;
			unsupported     <= dec.bad;
		end
	end

endmodule

/* design/mdms_checker.sv */
// ----------------------------------------------------------------------------
// mdms_checker
// Port-level checks of the data-move core, bound to the top level.
// ----------------------------------------------------------------------------
module mdms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] program_counter,
	input logic [7:0]  accumulator,
	input logic        xram_write,
	input logic [15:0] xram_address,
	input logic [7:0]  xram_data,
	input logic        unsupported
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(program_counter) && $stable(accumulator)
			&& $stable(xram_write) && $stable(xram_address) && $stable(xram_data)
			&& $stable(unsupported))
		else $error("result payload changed while stalled");

	// one request at a time: a taken request closes the input side
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	// an unsupported opcode never writes external memory
	a_bad_no_xram: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> !xram_write && xram_address == 16'd0
			&& xram_data == 8'd0)
		else $error("unsupported opcode drives external write");

	// no external write fields without the write strobe
	a_xram_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !xram_write |-> xram_address == 16'd0 && xram_data == 8'd0)
		else $error("external write fields set without strobe");

endmodule

bind mcs51_data_move_subset_core_unit mdms_checker u_mdms_checker (.*);

/* verif/mdms_exec_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mdms_exec_checker
// Watches both channels of the data-move core, predicts every result and
// compares it with what the core returns.
// ----------------------------------------------------------------------------
// Keeps a private copy of the internal RAM and PC. Each accepted request is
// executed on that copy and its result queued; each accepted result is
// checked against the oldest queued one.
// ----------------------------------------------------------------------------
module mdms_exec_checker
	import mdms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand_one,
	input  logic [7:0]  operand_two,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] program_counter,
	input  logic [7:0]  accumulator,
	input  logic        xram_write,
	input  logic [15:0] xram_address,
	input  logic [7:0]  xram_data,
	input  logic        unsupported,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  acc;
		logic        xw;
		logic [15:0] xa;
		logic [7:0]  xd;
		logic        bad;
	} exec_result_t;

	logic [7:0]   iram [256];
	logic [15:0]  pc_model;
	exec_result_t predicted_results [$];
	int           err_total;

	// Rn address in the bank that PSW selects right now
	function automatic logic [7:0] bank_reg(input logic [2:0] n);
		return {3'b000, iram[ADDR_PSW][4:3], n};
	endfunction

	// target of @R0 / @R1
	function automatic logic [7:0] ind_target(input logic sel);
		return iram[bank_reg({2'b00, sel})];
	endfunction

	task automatic execute_instruction(input logic [7:0] op, input logic [7:0] b1,
			input logic [7:0] b2);
		logic [3:0]   hi;
		logic [3:0]   lo;
		logic [7:0]   acc;
		logic [7:0]   t;
		logic [7:0]   v;
		logic [15:0]  len;
		exec_result_t r;
		hi  = op[7:4];
		lo  = op[3:0];
		acc = iram[ADDR_ACC];
		len = 16'd1;
		r   = '0;
		if ((hi == ROW_INC || hi == ROW_DEC) && lo >= COL_ACC) begin
			if (lo == COL_ACC) begin
				t = ADDR_ACC;
			end else if (lo == COL_DIR) begin
				t   = b1;
				len = 16'd2;
			end else if (!lo[3]) begin
				t = ind_target(lo[0]);
			end else begin
				t = bank_reg(lo[2:0]);
			end
			iram[t] = (hi == ROW_INC) ? iram[t] + 8'd1 : iram[t] - 8'd1;
		end else if (op == OP_RR_A) begin
			iram[ADDR_ACC] = {acc[0], acc[7:1]};
		end else if (op == OP_RL_A) begin
			iram[ADDR_ACC] = {acc[6:0], acc[7]};
		end else if (op == OP_SWAP_A) begin
			iram[ADDR_ACC] = {acc[3:0], acc[7:4]};
		end else if (op == OP_CLR_A) begin
			iram[ADDR_ACC] = 8'h00;
		end else if (hi == ROW_MOVIMM && lo >= COL_ACC) begin
			len = 16'd2;
			if (lo == COL_ACC) begin
				iram[ADDR_ACC] = b1;
			end else if (lo == COL_DIR) begin
				iram[b1] = b2;
				len      = 16'd3;
			end else if (!lo[3]) begin
				iram[ind_target(lo[0])] = b1;
			end else begin
				iram[bank_reg(lo[2:0])] = b1;
			end
		end else if (hi == ROW_MOVDIR && lo >= COL_DIR) begin
			if (lo == COL_DIR) begin
				// read the source before touching the destination
				v        = iram[b1];
				iram[b2] = v;
				len      = 16'd3;
			end else begin
				if (!lo[3]) begin
					v = iram[ind_target(lo[0])];
				end else begin
					v = iram[bank_reg(lo[2:0])];
				end
				iram[b1] = v;
				len      = 16'd2;
			end
		end else if (op == OP_MOV_DP) begin
			iram[ADDR_DPH] = b1;
			iram[ADDR_DPL] = b2;
			len            = 16'd3;
		end else if (hi == ROW_MOVTOR && lo >= COL_IND) begin
			v = iram[b1];
			if (!lo[3]) begin
				t = ind_target(lo[0]);
			end else begin
				t = bank_reg(lo[2:0]);
			end
			iram[t] = v;
			len     = 16'd2;
		end else if (hi == ROW_MOVTOA && lo >= COL_DIR) begin
			if (lo == COL_DIR) begin
				iram[ADDR_ACC] = iram[b1];
				len            = 16'd2;
			end else if (!lo[3]) begin
				iram[ADDR_ACC] = iram[ind_target(lo[0])];
			end else begin
				iram[ADDR_ACC] = iram[bank_reg(lo[2:0])];
			end
		end else if (op == OP_MOVX) begin
			r.xw = 1'b1;
			r.xa = {iram[ADDR_DPH], iram[ADDR_DPL]};
			r.xd = acc;
		end else if (hi == ROW_MOVFRA && lo >= COL_DIR) begin
			if (lo == COL_DIR) begin
				iram[b1] = acc;
				len      = 16'd2;
			end else if (!lo[3]) begin
				iram[ind_target(lo[0])] = acc;
			end else begin
				iram[bank_reg(lo[2:0])] = acc;
			end
		end else begin
			r.bad = 1'b1;
		end
		pc_model = pc_model + len;
		r.pc     = pc_model;
		r.acc    = iram[ADDR_ACC];
		predicted_results.push_back(r);
	endtask

	task automatic compare_result();
		exec_result_t want;
		exec_result_t got;
		got = {program_counter, accumulator, xram_write, xram_address, xram_data,
			unsupported};
		if (predicted_results.size() == 0) begin
			err_total++;
			if (err_total <= 10) begin
				$display("%0t: result with no request pending: pc=%h acc=%h xw=%b xa=%h xd=%h bad=%b",
					$realtime, got.pc, got.acc, got.xw, got.xa, got.xd, got.bad);
			end
		end else begin
			want = predicted_results.pop_front();
			if (got !== want) begin
				err_total++;
				if (err_total <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected pc=%h acc=%h xw=%b xa=%h xd=%h bad=%b",
						want.pc, want.acc, want.xw, want.xa, want.xd, want.bad);
					$display("  actual   pc=%h acc=%h xw=%b xa=%h xd=%h bad=%b",
						got.pc, got.acc, got.xw, got.xa, got.xd, got.bad);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) begin
				iram[i] = 8'h00;
			end
			pc_model = '0;
			predicted_results.delete();
			err_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready) begin
				execute_instruction(opcode, operand_one, operand_two);
			end
			if (out_valid && out_ready) begin
				compare_result();
			end
			mismatches  <= err_total;
			outstanding <= predicted_results.size();
		end
	end

endmodule

/* verif/mcs51_data_move_subset_core_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcs51_data_move_subset_core_unit_test
// Request stimulus and verdict for the 8051 data-move subset core.
// ----------------------------------------------------------------------------
// A directed run walks the extremes and each kind of instruction, then random
// instruction streams follow, biased toward register banks and SFR cells.
// The sender works in bursts, the receiver stalls in changing patterns, and
// the checker beside the core does all prediction and comparison.
// ----------------------------------------------------------------------------
module mcs51_data_move_subset_core_unit_test;
	import mdms_pkg::*;

	// opcode columns used only for directed requests
	localparam logic [3:0] COL_IND1 = 4'h7;
	localparam logic [3:0] COL_R0   = 4'h8;
	localparam logic [3:0] COL_R7   = 4'hF;

	// opcodes outside the subset
	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_RESERVED = 8'hA5;

	localparam int RANDOM_REQUESTS = 700;
	localparam int DRAIN_EVERY     = 150;
	localparam int SETTLE_CYCLES   = 20;
	localparam int RUN_LIMIT_NS    = 6_000_000;

	typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  opcode      = 8'h00;
	logic [7:0]  operand_one = 8'h00;
	logic [7:0]  operand_two = 8'h00;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [15:0] program_counter;
	logic [7:0]  accumulator;
	logic        xram_write;
	logic [15:0] xram_address;
	logic [7:0]  xram_data;
	logic        unsupported;

	int fails;
	int pending;

	// sender burst bookkeeping
	int burst_left = 0;

	// receiver stall pattern state
	rx_mode_t rx_mode  = RX_OPEN;
	int       rx_hold  = 0;
	int       rx_phase = 0;

	mcs51_data_move_subset_core_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.operand_one     (operand_one),
		.operand_two     (operand_two),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.program_counter (program_counter),
		.accumulator     (accumulator),
		.xram_write      (xram_write),
		.xram_address    (xram_address),
		.xram_data       (xram_data),
		.unsupported     (unsupported)
	);

	mdms_exec_checker exec_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.operand_one     (operand_one),
		.operand_two     (operand_two),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.program_counter (program_counter),
		.accumulator     (accumulator),
		.xram_write      (xram_write),
		.xram_address    (xram_address),
		.xram_data       (xram_data),
		.unsupported     (unsupported),
		.mismatches      (fails),
		.outstanding     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run, including the RAM sweep.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: hold one stall pattern for a random stretch, then pick another.
	// Open stretches never stall results; sparse ones stall for long runs.
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_hold = $urandom_range(40, 400);
		end
		rx_hold  = rx_hold - 1;
		rx_phase = rx_phase + 1;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= ((rx_phase % 7) < 3);
		endcase
	end

	// Present one request, hold it until taken, then maybe drop valid for a gap.
	// Valid stays high between requests of one burst.
	task automatic send_request(input logic [7:0] op, input logic [7:0] b1,
			input logic [7:0] b2);
		int gap;
		in_valid    <= 1'b1;
		opcode      <= op;
		operand_one <= b1;
		operand_two <= b2;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = $urandom_range(0, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and hold until every predicted result has come back.
	// The first edge lets the checker count a request taken at this edge.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Operand bytes: lean on the register banks and the SFR cells that matter.
	function automatic logic [7:0] pick_operand();
		int r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return {3'b000, r[4:0]};
			4, 5: begin
				case (r[1:0])
					2'd0:    return ADDR_ACC;
					2'd1:    return ADDR_PSW;
					2'd2:    return ADDR_DPL;
					default: return ADDR_DPH;
				endcase
			end
			default: return r[7:0];
		endcase
	endfunction

	// One random instruction: mostly subset forms, some bank switches, DPTR
	// traffic and plain noise opcodes that fall outside the subset.
	task automatic random_request();
		int         r;
		int         c;
		logic [7:0] op;
		logic [7:0] b1;
		logic [7:0] b2;
		r  = $urandom;
		b1 = pick_operand();
		b2 = pick_operand();
		case ($urandom_range(0, 9))
			0: begin
				c  = $urandom_range(4, 15);
				op = {(r[8] ? ROW_DEC : ROW_INC), c[3:0]};
			end
			1: begin
				c  = $urandom_range(4, 15);
				op = {ROW_MOVIMM, c[3:0]};
				// immediates are full range, not address-shaped
				if (r[9]) b1 = r[7:0];
			end
			2: begin
				c  = $urandom_range(5, 15);
				op = {ROW_MOVDIR, c[3:0]};
			end
			3: begin
				c  = $urandom_range(6, 15);
				op = {ROW_MOVTOR, c[3:0]};
			end
			4: begin
				c  = $urandom_range(5, 15);
				op = {ROW_MOVTOA, c[3:0]};
			end
			5: begin
				c  = $urandom_range(5, 15);
				op = {ROW_MOVFRA, c[3:0]};
			end
			6: begin
				case ($urandom_range(0, 3))
					0:       op = OP_RR_A;
					1:       op = OP_RL_A;
					2:       op = OP_SWAP_A;
					default: op = OP_CLR_A;
				endcase
			end
			7: begin
				// switch register bank
				op = {ROW_MOVIMM, COL_DIR};
				b1 = ADDR_PSW;
				b2 = r[7:0];
			end
			8: begin
				if (r[10]) begin
					op = OP_MOV_DP;
					b1 = r[15:8];
					b2 = r[23:16];
				end else begin
					op = OP_MOVX;
				end
			end
			default: op = r[31:24];
		endcase
		send_request(op, b1, b2);
	endtask

	initial begin
		// reset once; the core then sweeps its RAM on its own
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// accumulator wrap both ways
		send_request({ROW_MOVIMM, COL_ACC}, 8'hFF, 8'h00);
		send_request({ROW_INC, COL_ACC}, 8'h00, 8'h00);
		send_request({ROW_DEC, COL_ACC}, 8'h00, 8'h00);
		// move to bank 3, then build a pointer into the SFR half of RAM
		send_request({ROW_MOVIMM, COL_DIR}, ADDR_PSW, 8'h18);
		send_request({ROW_MOVIMM, COL_R0}, 8'h80, 8'hFF);
		send_request({ROW_MOVIMM, COL_IND}, 8'h5A, 8'hFF);
		send_request({ROW_INC, COL_IND}, 8'hFF, 8'hFF);
		send_request({ROW_DEC, COL_R7}, 8'h00, 8'h00);
		// direct write lands on ACC
		send_request({ROW_MOVIMM, COL_DIR}, ADDR_ACC, 8'h81);
		send_request(OP_RR_A, 8'hFF, 8'hFF);
		send_request(OP_RL_A, 8'h00, 8'h00);
		send_request(OP_SWAP_A, 8'hFF, 8'h00);
		// direct-to-direct: ACC into PSW rewrites the bank select, again with bank 3
		send_request({ROW_MOVDIR, COL_DIR}, ADDR_ACC, ADDR_PSW);
		send_request({ROW_MOVDIR, COL_DIR}, 8'hFF, 8'hFF);
		send_request({ROW_MOVFRA, COL_R7}, 8'h00, 8'h00);
		send_request({ROW_MOVTOA, COL_IND1}, 8'h00, 8'h00);
		send_request({ROW_MOVTOR, COL_R0}, ADDR_DPH, 8'h00);
		send_request({ROW_MOVTOR, COL_IND}, 8'h00, 8'h00);
		send_request({ROW_MOVDIR, COL_R7}, 8'h00, 8'hFF);
		send_request({ROW_MOVDIR, COL_IND1}, ADDR_ACC, 8'h00);
		// external write at both address extremes
		send_request(OP_MOV_DP, 8'hFF, 8'hFF);
		send_request(OP_MOVX, 8'h00, 8'h00);
		send_request(OP_MOV_DP, 8'h00, 8'h00);
		send_request(OP_CLR_A, 8'hFF, 8'hFF);
		send_request(OP_MOVX, 8'hFF, 8'hFF);
		send_request({ROW_INC, COL_DIR}, 8'hFF, 8'h00);
		send_request({ROW_MOVTOA, COL_DIR}, 8'hFF, 8'h00);
		send_request({ROW_MOVFRA, COL_DIR}, 8'h00, 8'hFF);
		// outside the subset
		send_request(OP_NOP, 8'hFF, 8'hFF);
		send_request(OP_RESERVED, 8'h00, 8'h00);

		// let the pipe run dry before the random part
		wait_for_results();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			random_request();
			if ((n % DRAIN_EVERY) == (DRAIN_EVERY - 1)) begin
				wait_for_results();
			end
		end

		// drain, then watch a little longer for stray results
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fails == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
